@@ rtl/json_string_unescape_utf8_defines.svh @@
// Assertion macros shared by the checker of the JSON string unescaper.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/jsu_pkg.sv @@
// Types and codes of the JSON string unescaper.
// Used by every module of the block; depends on nothing.
package jsu_pkg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic [3:0] error_code;
        logic       run_last;
    } out_item_t;

    // All results caused by one input byte; cnt is 0 to 4.
    typedef struct packed {
        logic [2:0]      cnt;
        logic [1:0]      kind;
        logic [3:0]      err;
        logic [3:0][7:0] bytes;
    } burst_t;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_CLOSED = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_ENDED  = 2'd3;

    localparam logic [3:0] ERR_NONE         = 4'd0;
    localparam logic [3:0] ERR_CONTROL      = 4'd1;
    localparam logic [3:0] ERR_BAD_ESCAPE   = 4'd2;
    localparam logic [3:0] ERR_BAD_HEX      = 4'd3;
    localparam logic [3:0] ERR_NO_LOW       = 4'd4;
    localparam logic [3:0] ERR_LOW_RANGE    = 4'd5;
    localparam logic [3:0] ERR_LONE_LOW     = 4'd6;
    localparam logic [3:0] ERR_UNTERMINATED = 4'd7;
    localparam logic [3:0] ERR_NO_QUOTE     = 4'd8;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;

endpackage

@@ rtl/jsu_front.sv @@
// Front end of the JSON string unescaper: parses one byte per transfer and
// turns it into a burst of up to four results. Depends on jsu_pkg.
module jsu_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  jsu_pkg::in_item_t item,
    output logic             push,
    output jsu_pkg::burst_t  push_data
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_STR,
        PH_ESC,
        PH_HEX1,
        PH_WBS,
        PH_WU,
        PH_HEX2,
        PH_ERR
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] code_unit_reg, code_unit_next;
    logic [1:0]  digit_count_reg, digit_count_next;
    logic [9:0]  high_half_reg, high_half_next;

    logic        nib_ok;
    logic [3:0]  nib;
    logic [15:0] cu_hex;
    logic        hex_done;
    logic [20:0] pair_cp;
    jsu_pkg::burst_t burst;

    function automatic jsu_pkg::burst_t single(input logic [1:0] kind, input logic [7:0] data,
                                               input logic [3:0] err);
        jsu_pkg::burst_t r;
        r          = '0;
        r.cnt      = 3'd1;
        r.kind     = kind;
        r.err      = err;
        r.bytes[0] = data;
        return r;
    endfunction

    function automatic jsu_pkg::burst_t utf8(input logic [20:0] cp);
        jsu_pkg::burst_t r;
        r      = '0;
        r.kind = jsu_pkg::KIND_BYTE;
        r.err  = jsu_pkg::ERR_NONE;
        if (cp <= 21'h7F) begin
            r.cnt      = 3'd1;
            r.bytes[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            r.cnt      = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            r.cnt      = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            r.cnt      = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    always_comb begin
        nib_ok = 1'b1;
        nib    = 4'd0;
        if (item.in_byte >= 8'h30 && item.in_byte <= 8'h39) begin
            nib = item.in_byte[3:0];
        end else if ((item.in_byte >= 8'h61 && item.in_byte <= 8'h66)
                     || (item.in_byte >= 8'h41 && item.in_byte <= 8'h46)) begin
            nib = item.in_byte[3:0] + 4'd9;
        end else begin
            nib_ok = 1'b0;
        end
    end

    assign cu_hex   = {code_unit_reg[11:0], nib};
    assign hex_done = nib_ok && (digit_count_reg == 2'd3);
    // Joined code point of a surrogate pair; the low unit's top six bits are known.
    assign pair_cp  = 21'h10000 + {1'b0, high_half_reg, cu_hex[9:0]};

    always_comb begin
        phase_next       = phase_reg;
        code_unit_next   = code_unit_reg;
        digit_count_next = digit_count_reg;
        high_half_next   = high_half_reg;
        burst            = '0;

        if (item.cmd == jsu_pkg::CMD_END) begin
            if (phase_reg == PH_IDLE) begin
                burst = single(jsu_pkg::KIND_ENDED, 8'd0, jsu_pkg::ERR_NONE);
            end else if (phase_reg != PH_ERR) begin
                burst = single(jsu_pkg::KIND_ERROR, 8'd0, jsu_pkg::ERR_UNTERMINATED);
            end
            phase_next       = PH_IDLE;
            code_unit_next   = '0;
            digit_count_next = '0;
            high_half_next   = '0;
        end else begin
            case (phase_reg)
                PH_IDLE: begin
                    if (item.in_byte == jsu_pkg::CH_QUOTE) begin
                        phase_next = PH_STR;
                    end else if (item.in_byte != jsu_pkg::CH_SPACE
                                 && item.in_byte != jsu_pkg::CH_TAB
                                 && item.in_byte != jsu_pkg::CH_LF
                                 && item.in_byte != jsu_pkg::CH_CR) begin
                        burst      = single(jsu_pkg::KIND_ERROR, 8'd0, jsu_pkg::ERR_NO_QUOTE);
                        phase_next = PH_ERR;
                    end
                end
                PH_STR: begin
                    if (item.in_byte == jsu_pkg::CH_QUOTE) begin
                        burst      = single(jsu_pkg::KIND_CLOSED, 8'd0, jsu_pkg::ERR_NONE);
                        phase_next = PH_IDLE;
                    end else if (item.in_byte < jsu_pkg::CH_SPACE) begin
                        burst      = single(jsu_pkg::KIND_ERROR, 8'd0, jsu_pkg::ERR_CONTROL);
                        phase_next = PH_ERR;
                    end else if (item.in_byte == jsu_pkg::CH_BACKSLASH) begin
                        phase_next = PH_ESC;
                    end else begin
                        burst = single(jsu_pkg::KIND_BYTE, item.in_byte, jsu_pkg::ERR_NONE);
                    end
                end
                PH_ESC: begin
                    phase_next = PH_STR;
                    case (item.in_byte)
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH:
                            burst = single(jsu_pkg::KIND_BYTE, item.in_byte, jsu_pkg::ERR_NONE);
                        jsu_pkg::CH_LOWER_B:
                            burst = single(jsu_pkg::KIND_BYTE, jsu_pkg::CH_BS, jsu_pkg::ERR_NONE);
                        jsu_pkg::CH_LOWER_F:
                            burst = single(jsu_pkg::KIND_BYTE, jsu_pkg::CH_FF, jsu_pkg::ERR_NONE);
                        jsu_pkg::CH_LOWER_N:
                            burst = single(jsu_pkg::KIND_BYTE, jsu_pkg::CH_LF, jsu_pkg::ERR_NONE);
                        jsu_pkg::CH_LOWER_R:
                            burst = single(jsu_pkg::KIND_BYTE, jsu_pkg::CH_CR, jsu_pkg::ERR_NONE);
                        jsu_pkg::CH_LOWER_T:
                            burst = single(jsu_pkg::KIND_BYTE, jsu_pkg::CH_TAB, jsu_pkg::ERR_NONE);
                        jsu_pkg::CH_LOWER_U: begin
                            code_unit_next   = '0;
                            digit_count_next = '0;
                            phase_next       = PH_HEX1;
                        end
                        default: begin
                            burst = single(jsu_pkg::KIND_ERROR, 8'd0, jsu_pkg::ERR_BAD_ESCAPE);
                            phase_next = PH_ERR;
                        end
                    endcase
                end
                PH_HEX1, PH_HEX2: begin
                    if (!nib_ok) begin
                        burst      = single(jsu_pkg::KIND_ERROR, 8'd0, jsu_pkg::ERR_BAD_HEX);
                        phase_next = PH_ERR;
                    end else begin
                        code_unit_next   = cu_hex;
                        digit_count_next = digit_count_reg + 2'd1;
                    end
                    if (hex_done) begin
                        if (phase_reg == PH_HEX1) begin
                            // Bits 15:11 equal to 11011 mark the surrogate range.
                            if (cu_hex[15:11] == 5'b11011 && !cu_hex[10]) begin
                                high_half_next = cu_hex[9:0];
                                phase_next     = PH_WBS;
                            end else if (cu_hex[15:11] == 5'b11011) begin
                                burst = single(jsu_pkg::KIND_ERROR, 8'd0,
                                               jsu_pkg::ERR_LONE_LOW);
                                phase_next = PH_ERR;
                            end else begin
                                burst      = utf8({5'd0, cu_hex});
                                phase_next = PH_STR;
                            end
                        end else begin
                            if (cu_hex[15:10] != 6'b110111) begin
                                burst = single(jsu_pkg::KIND_ERROR, 8'd0,
                                               jsu_pkg::ERR_LOW_RANGE);
                                phase_next = PH_ERR;
                            end else begin
                                burst      = utf8(pair_cp);
                                phase_next = PH_STR;
                            end
                        end
                    end
                end
                PH_WBS: begin
                    if (item.in_byte == jsu_pkg::CH_BACKSLASH) begin
                        phase_next = PH_WU;
                    end else begin
                        burst      = single(jsu_pkg::KIND_ERROR, 8'd0, jsu_pkg::ERR_NO_LOW);
                        phase_next = PH_ERR;
                    end
                end
                PH_WU: begin
                    if (item.in_byte == jsu_pkg::CH_LOWER_U) begin
                        code_unit_next   = '0;
                        digit_count_next = '0;
                        phase_next       = PH_HEX2;
                    end else begin
                        burst      = single(jsu_pkg::KIND_ERROR, 8'd0, jsu_pkg::ERR_NO_LOW);
                        phase_next = PH_ERR;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign push      = take && (burst.cnt != 3'd0);
    assign push_data = burst;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg       <= PH_IDLE;
            code_unit_reg   <= '0;
            digit_count_reg <= '0;
            high_half_reg   <= '0;
        end else if (take) begin
            phase_reg       <= phase_next;
            code_unit_reg   <= code_unit_next;
            digit_count_reg <= digit_count_next;
            high_half_reg   <= high_half_next;
        end
    end

endmodule

@@ rtl/jsu_fifo.sv @@
// Short queue of result bursts between the parser and the serializer.
// Depends on jsu_pkg for the burst type.
module jsu_fifo #(
    parameter int Depth = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  jsu_pkg::burst_t push_data,
    input  logic            pop,
    output jsu_pkg::burst_t pop_data,
    output logic            full,
    output logic            empty
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    jsu_pkg::burst_t mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign full     = (count_reg == CntW'(Depth));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/jsu_back.sv @@
// Back end of the JSON string unescaper: unpacks queued bursts into single
// results, one per cycle when not stalled, via an output register. Depends on jsu_pkg.
module jsu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               empty,
    input  jsu_pkg::burst_t    pop_data,
    output logic               pop,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output jsu_pkg::out_item_t rsp
);

    jsu_pkg::burst_t    cur_reg;
    logic               cur_valid_reg;
    logic [1:0]         idx_reg;
    logic               rsp_valid_reg;
    jsu_pkg::out_item_t rsp_reg;

    logic               adv;
    logic               last;
    jsu_pkg::out_item_t entry;

    // The output register may load whenever it is empty or its transfer completes.
    assign adv  = !rsp_valid_reg || !rsp_stall;
    assign last = cur_valid_reg && (({1'b0, idx_reg} + 3'd1) == cur_reg.cnt);
    assign pop  = !empty && (!cur_valid_reg || (adv && last));

    always_comb begin
        entry.out_kind   = cur_reg.kind;
        entry.out_byte   = cur_reg.bytes[idx_reg];
        entry.error_code = cur_reg.err;
        entry.run_last   = last;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_valid_reg <= 1'b0;
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            if (adv) begin
                rsp_valid_reg <= cur_valid_reg;
            end
            if (pop) begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end else if (adv && cur_valid_reg) begin
                if (last) begin
                    cur_valid_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (pop) begin
            cur_reg <= pop_data;
        end
        if (adv && cur_valid_reg) begin
            rsp_reg <= entry;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/json_string_unescape_utf8.sv @@
// JSON string unescaper to UTF-8. An accepted byte's results pass the burst
// queue, the burst register and the output register. Throughput: one input
// byte per cycle and one result per cycle while rsp_stall is low; a \u escape
// of k bytes gives k results; the FifoDepth queue stalls the input when full.
// Reset clears the parser to idle before an opening quote and empties the queue.
module json_string_unescape_utf8 #(
    parameter int FifoDepth = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  jsu_pkg::in_item_t  req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output jsu_pkg::out_item_t rsp
);

    logic            take;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    jsu_pkg::burst_t push_data;
    jsu_pkg::burst_t pop_data;

    assign req_stall = full;
    assign take      = req_valid && !full;

    jsu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (req),
        .push      (push),
        .push_data (push_data)
    );

    jsu_fifo #(
        .Depth (FifoDepth)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .pop_data  (pop_data),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

@@ rtl/jsu_checker.sv @@
// Port-level checks of the JSON string unescaper, bound to the top level.
// Depends on jsu_pkg and json_string_unescape_utf8_defines.svh.
`include "json_string_unescape_utf8_defines.svh"

module jsu_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input jsu_pkg::out_item_t rsp
);

    `JSU_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp),
                     "result changed while stalled")
    `JSU_ASSERT_NOW(a_single_last, rsp_valid && rsp.out_kind != jsu_pkg::KIND_BYTE,
                    rsp.run_last, "non-byte result is not last of its run")
    `JSU_ASSERT_NOW(a_err_code, rsp_valid && rsp.out_kind != jsu_pkg::KIND_ERROR,
                    rsp.error_code == jsu_pkg::ERR_NONE, "error code set on a non-error result")
    `JSU_ASSERT_NOW(a_byte_zero, rsp_valid && rsp.out_kind != jsu_pkg::KIND_BYTE,
                    rsp.out_byte == 8'd0, "byte set on a non-byte result")

endmodule

bind json_string_unescape_utf8 jsu_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
